/* hw/rtl/ecs_pkg.sv */
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared types, sizes and codes of the element-centric similarity block.
// ----------------------------------------------------------------------------
package ecs_pkg;

    localparam int CLUSTERS_A   = 64;
    localparam int CLUSTERS_B   = 64;
    localparam int MAX_ELEMENTS = 65536;

    localparam int IA_W    = $clog2(CLUSTERS_A);
    localparam int IB_W    = $clog2(CLUSTERS_B);
    localparam int PAIR_W  = IA_W + IB_W;
    localparam int PAIRS   = CLUSTERS_A * CLUSTERS_B;
    localparam int CNT_W   = 17;
    localparam int SUM_W   = 33;
    localparam int Q_W     = 17;
    localparam int CFG_W   = 16;
    localparam int CLR_W   = (PAIR_W > IA_W ? PAIR_W : IA_W) + 1;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
    localparam logic [Q_W-1:0]   Q_ONE   = Q_W'(65536);

    typedef enum logic [1:0] {
        REQ_ACC   = 2'd0,
        REQ_SCORE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    localparam logic CFG_OFFSET_A = 1'b0;
    localparam logic CFG_OFFSET_B = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_LOOK, S_ACC_WR, S_DIV1, S_DIV1_RUN,
        S_DIV2, S_DIV2_RUN, S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] label_a;
        logic [15:0] label_b;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]     status;
        logic [Q_W-1:0] score;
        logic [Q_W-1:0] average;
        logic           average_valid;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

/* hw/rtl/element_centric_similarity.sv */
// Request to result: an accumulate passes through read, lookup, table write and output (the
// write is skipped when rejected); clear and the unused selector go to output after lookup; a
// score runs one 34-step radix-2 divide, a score marked last two divides, or only the average
// divide, or none. Only one request is in flight; the next is taken once its result is queued.
// After reset and after each clear result the pair table is swept, one entry a cycle, through
// all 4096 entries, during which no request is taken. Reset zeroes offsets, table, count and sum.
// ----------------------------------------------------------------------------
// element_centric_similarity
// Contingency table of label pairs with element-centric scores and average.
// ----------------------------------------------------------------------------
module element_centric_similarity (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ecs_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ecs_pkg::out_item_t           m_data,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [ecs_pkg::CFG_W-1:0]    cfg_data
);

    localparam int IA_W   = ecs_pkg::IA_W;
    localparam int IB_W   = ecs_pkg::IB_W;
    localparam int PAIR_W = ecs_pkg::PAIR_W;
    localparam int CNT_W  = ecs_pkg::CNT_W;
    localparam int SUM_W  = ecs_pkg::SUM_W;
    localparam int Q_W    = ecs_pkg::Q_W;
    localparam int CLR_W  = ecs_pkg::CLR_W;

    ecs_pkg::state_t state_reg, state_next;

    logic [15:0]          off_a_reg, off_b_reg;
    ecs_pkg::in_item_t    item_reg;
    logic [IA_W-1:0]      ia_reg;
    logic [IB_W-1:0]      ib_reg;
    logic                 range_ok_reg;
    logic [CLR_W-1:0]     clr_reg, clr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     c_reg, m_reg;
    logic [1:0]           status_reg;
    logic [Q_W-1:0]       score_reg, avg_reg;
    ecs_pkg::out_item_t   out_reg;
    logic                 out_valid_reg;

    // Label mapping
    logic [16:0] da, db;
    logic        in_range;
    assign da = {1'b0, s_data.label_a} - {1'b0, off_a_reg};
    assign db = {1'b0, s_data.label_b} - {1'b0, off_b_reg};
    assign in_range = !da[16] && (da[15:0] < 16'(ecs_pkg::CLUSTERS_A)) &&
                      !db[16] && (db[15:0] < 16'(ecs_pkg::CLUSTERS_B));

    // Memories
    logic                 pc_we, rt_we, ct_we;
    logic [PAIR_W-1:0]    pc_addr;
    logic [IA_W-1:0]      rt_addr;
    logic [IB_W-1:0]      ct_addr;
    logic [CNT_W-1:0]     pc_wd, rt_wd, ct_wd, pc_rd, rt_rd, ct_rd;
    logic                 clearing;

    assign clearing = (state_reg == ecs_pkg::S_CLEAR);
    assign pc_addr  = clearing ? clr_reg[PAIR_W-1:0] : {ia_reg, ib_reg};
    assign rt_addr  = clearing ? clr_reg[IA_W-1:0] : ia_reg;
    assign ct_addr  = clearing ? clr_reg[IB_W-1:0] : ib_reg;
    assign pc_wd    = clearing ? '0 : pc_rd + 1'b1;
    assign rt_wd    = clearing ? '0 : rt_rd + 1'b1;
    assign ct_wd    = clearing ? '0 : ct_rd + 1'b1;
    assign pc_we    = clearing || (state_reg == ecs_pkg::S_ACC_WR);
    assign rt_we    = (clearing && clr_reg < CLR_W'(ecs_pkg::CLUSTERS_A)) ||
                      (state_reg == ecs_pkg::S_ACC_WR);
    assign ct_we    = (clearing && clr_reg < CLR_W'(ecs_pkg::CLUSTERS_B)) ||
                      (state_reg == ecs_pkg::S_ACC_WR);

    ecs_ram #(.WIDTH(CNT_W), .DEPTH(ecs_pkg::PAIRS)) u_pairs (
        .aclk(aclk), .we(pc_we), .waddr(pc_addr), .wdata(pc_wd),
        .raddr(pc_addr), .rdata(pc_rd));
    ecs_ram #(.WIDTH(CNT_W), .DEPTH(ecs_pkg::CLUSTERS_A)) u_rows (
        .aclk(aclk), .we(rt_we), .waddr(rt_addr), .wdata(rt_wd),
        .raddr(rt_addr), .rdata(rt_rd));
    ecs_ram #(.WIDTH(CNT_W), .DEPTH(ecs_pkg::CLUSTERS_B)) u_cols (
        .aclk(aclk), .we(ct_we), .waddr(ct_addr), .wdata(ct_wd),
        .raddr(ct_addr), .rdata(ct_rd));

    // Divider
    logic                 div_start;
    logic [SUM_W:0]       div_dividend, div_q;
    logic [CNT_W-1:0]     div_divisor;
    ecs_pkg::div_ctl_t    div_ctl;
    logic [SUM_W:0]       sum_new;
    logic [SUM_W-1:0]     sum_sat;

    assign sum_new = {1'b0, sum_reg} + {{(SUM_W+1-Q_W){1'b0}}, score_reg};
    // The second divide reads the sum with this item's score already added.
    assign sum_sat = sum_new[SUM_W] ? '1 : sum_new[SUM_W-1:0];
    assign div_start = (state_reg == ecs_pkg::S_DIV1) || (state_reg == ecs_pkg::S_DIV2);
    assign div_dividend = (state_reg == ecs_pkg::S_DIV1)
                          ? {{(SUM_W+1-CNT_W-16){1'b0}}, c_reg, 16'h0000}
                          : {1'b0, sum_sat};
    assign div_divisor = (state_reg == ecs_pkg::S_DIV1) ? m_reg : count_reg;

    ecs_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dividend), .divisor(div_divisor),
        .quotient(div_q), .ctl(div_ctl));

    logic [SUM_W:0] q_one_w;
    assign q_one_w = {{(SUM_W+1-Q_W){1'b0}}, ecs_pkg::Q_ONE};

    // Next state
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ecs_pkg::S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(ecs_pkg::PAIRS - 1)) begin
                    state_next = ecs_pkg::S_IDLE;
                end
            end
            ecs_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ecs_pkg::S_READ;
                end
            end
            ecs_pkg::S_READ: begin
                state_next = ecs_pkg::S_LOOK;
            end
            ecs_pkg::S_LOOK: begin
                case (item_reg.req_type)
                    ecs_pkg::REQ_ACC: begin
                        if (range_ok_reg && count_reg < ecs_pkg::MAX_CNT) begin
                            state_next = ecs_pkg::S_ACC_WR;
                        end else begin
                            state_next = ecs_pkg::S_OUT;
                        end
                    end
                    ecs_pkg::REQ_SCORE: begin
                        if (range_ok_reg && pc_rd != '0) begin
                            state_next = ecs_pkg::S_DIV1;
                        end else if (item_reg.last && count_reg != '0) begin
                            state_next = ecs_pkg::S_DIV2;
                        end else begin
                            state_next = ecs_pkg::S_OUT;
                        end
                    end
                    default: state_next = ecs_pkg::S_OUT;
                endcase
            end
            ecs_pkg::S_ACC_WR: state_next = ecs_pkg::S_OUT;
            ecs_pkg::S_DIV1:   state_next = ecs_pkg::S_DIV1_RUN;
            ecs_pkg::S_DIV1_RUN: begin
                if (div_ctl.done) begin
                    state_next = (item_reg.last && count_reg != '0) ? ecs_pkg::S_DIV2
                                                                   : ecs_pkg::S_OUT;
                end
            end
            ecs_pkg::S_DIV2: state_next = ecs_pkg::S_DIV2_RUN;
            ecs_pkg::S_DIV2_RUN: begin
                if (div_ctl.done) begin
                    state_next = ecs_pkg::S_OUT;
                end
            end
            ecs_pkg::S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    // A clear request sweeps the table once its result is queued.
                    if (item_reg.req_type == ecs_pkg::REQ_CLEAR) begin
                        clr_next   = '0;
                        state_next = ecs_pkg::S_CLEAR;
                    end else begin
                        state_next = ecs_pkg::S_IDLE;
                    end
                end
            end
            default: state_next = ecs_pkg::S_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ecs_pkg::S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ecs_pkg::S_CLEAR;
            clr_reg       <= '0;
            off_a_reg     <= '0;
            off_b_reg     <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we) begin
                if (cfg_index == ecs_pkg::CFG_OFFSET_A) begin
                    off_a_reg <= cfg_data;
                end else begin
                    off_b_reg <= cfg_data;
                end
            end
            if (state_reg == ecs_pkg::S_OUT && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ecs_pkg::S_LOOK: begin
                    if (item_reg.req_type == ecs_pkg::REQ_CLEAR) begin
                        count_reg <= '0;
                        sum_reg   <= '0;
                    end
                end
                ecs_pkg::S_ACC_WR: count_reg <= count_reg + 1'b1;
                ecs_pkg::S_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        if (item_reg.req_type == ecs_pkg::REQ_SCORE) begin
                            if (item_reg.last) begin
                                sum_reg <= '0;
                            end else begin
                                sum_reg <= sum_sat;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        // Payload registers
        if (s_valid && s_ready) begin
            item_reg     <= s_data;
            ia_reg       <= da[IA_W-1:0];
            ib_reg       <= db[IB_W-1:0];
            range_ok_reg <= in_range;
        end
        case (state_reg)
            ecs_pkg::S_READ: begin
                score_reg  <= '0;
                avg_reg    <= '0;
                status_reg <= range_ok_reg ? ecs_pkg::ST_OK : ecs_pkg::ST_RANGE;
            end
            ecs_pkg::S_LOOK: begin
                c_reg <= pc_rd;
                m_reg <= (rt_rd > ct_rd) ? rt_rd : ct_rd;
                if (item_reg.req_type == ecs_pkg::REQ_ACC) begin
                    if (range_ok_reg && count_reg >= ecs_pkg::MAX_CNT) begin
                        status_reg <= ecs_pkg::ST_SAT;
                    end
                end else if (item_reg.req_type == ecs_pkg::REQ_SCORE) begin
                    if (range_ok_reg && pc_rd == '0) begin
                        status_reg <= ecs_pkg::ST_EMPTY;
                    end
                    // With no score the sum to average is the old one.
                    if (!(range_ok_reg && pc_rd != '0)) begin
                        score_reg <= '0;
                    end
                end else begin
                    status_reg <= ecs_pkg::ST_OK;
                end
            end
            ecs_pkg::S_DIV1_RUN: begin
                if (div_ctl.done) begin
                    score_reg <= (div_q > q_one_w) ? ecs_pkg::Q_ONE : div_q[Q_W-1:0];
                end
            end
            ecs_pkg::S_DIV2_RUN: begin
                if (div_ctl.done) begin
                    avg_reg <= (div_q > q_one_w) ? ecs_pkg::Q_ONE : div_q[Q_W-1:0];
                end
            end
            ecs_pkg::S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_reg.status        <= status_reg;
                    out_reg.score         <= score_reg;
                    out_reg.average       <= avg_reg;
                    out_reg.average_valid <= (item_reg.req_type == ecs_pkg::REQ_SCORE)
                                             && item_reg.last;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* hw/rtl/ecs_ram.sv */
// ----------------------------------------------------------------------------
// ecs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ecs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ecs_divider.sv */
// ----------------------------------------------------------------------------
// ecs_divider
// Radix-2 restoring divider, one quotient bit per cycle, 34-bit dividend.
// ----------------------------------------------------------------------------
module ecs_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ecs_pkg::SUM_W:0]     dividend,
    input  logic [ecs_pkg::CNT_W-1:0]   divisor,
    output logic [ecs_pkg::SUM_W:0]     quotient,
    output ecs_pkg::div_ctl_t           ctl
);

    localparam int N = ecs_pkg::SUM_W + 1;

    logic [N-1:0]                 q_reg, q_next;
    logic [ecs_pkg::CNT_W:0]      r_reg, r_next;
    logic [ecs_pkg::CNT_W-1:0]    d_reg, d_next;
    logic [$clog2(N+1)-1:0]       n_reg, n_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [ecs_pkg::CNT_W+1:0]    trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[N-1]} - {2'b00, d_reg};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            n_next    = ($clog2(N+1))'(N);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so one subtract decides the bit.
            if (!trial[ecs_pkg::CNT_W+1]) begin
                r_next = trial[ecs_pkg::CNT_W:0];
                q_next = {q_reg[N-2:0], 1'b1};
            end else begin
                r_next = {r_reg[ecs_pkg::CNT_W-1:0], q_reg[N-1]};
                q_next = {q_reg[N-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == 1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            n_reg    <= n_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient  = q_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

endmodule

/* hw/rtl/ecs_checker.sv */
// ----------------------------------------------------------------------------
// ecs_checker
// Port-level checks of the element-centric similarity block.
// ----------------------------------------------------------------------------
module ecs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input ecs_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.score <= ecs_pkg::Q_ONE && m_data.average <= ecs_pkg::Q_ONE)
        else $error("score above one");

    a_avg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.average_valid |-> m_data.average == '0)
        else $error("average without valid flag");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

endmodule

bind element_centric_similarity ecs_checker u_ecs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
